FILE: src/ialu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the integer ALU with divide/GCD/LCM/factorial.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int DataWidth = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MOD  = 3'd4,
        OP_FACT = 3'd5,
        OP_GCD  = 3'd6,
        OP_LCM  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_NONPOS   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_MUL_WAIT,
        S_FACT,
        S_GCD_DIV,
        S_GCD_STEP,
        S_LCM_DIV,
        S_LCM_MUL,
        S_OUT
    } state_t;

    // divider request / response between the sequencer and the divider
    typedef struct packed {
        logic                 start;
        logic [DataWidth-1:0] dividend;
        logic [DataWidth-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DataWidth-1:0] quot;
        logic [DataWidth-1:0] rem;
    } div_rsp_t;

endpackage

FILE: src/ialu_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ialu_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  ialu_pkg::div_req_t req,
    output ialu_pkg::div_rsp_t rsp
);
    import ialu_pkg::*;

    localparam int CntW = $clog2(DataWidth + 1);

    logic [DataWidth-1:0] quot_reg, quot_next;
    logic [DataWidth-1:0] rem_reg, rem_next;
    logic [DataWidth-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DataWidth:0]   trial;
    logic [DataWidth:0]   diff;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[DataWidth-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = CntW'(DataWidth);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DataWidth]) begin
                rem_next  = diff[DataWidth-1:0];
                quot_next = {quot_reg[DataWidth-2:0], 1'b1};
            end else begin
                rem_next  = trial[DataWidth-1:0];
                quot_next = {quot_reg[DataWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: src/integer_alu_with_gcd_lcm_factorial_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_gcd_lcm_factorial_unit
// Integer ALU: add, sub, mul, div, mod, factorial, gcd, lcm with status.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_axis   in   tdata: operand_a[31:0] operand_b[63:32]; tuser: req_type[2:0]
// m_axis   out  tdata: result[31:0]; tuser: status[1:0]
//
// Add/sub, divide by zero and nonpositive gcd/lcm operands go straight to
// the output; mul waits on the registered product; div/mod use the shared
// 32-step divider. Factorial of n multiplies 1..n, stopping once the product
// is zero (from 34! on); n <= 0 gives 1. GCD: one divide per Euclid step.
// LCM: GCD, a divide, a multiply. One beat in flight; s_tready is low from
// acceptance until the result beat is taken. Reset clears the sequencer only.
// ----------------------------------------------------------------------------
module integer_alu_with_gcd_lcm_factorial_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // operand_a, operand_b
    input  logic [2:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // result
    output logic [1:0]  m_tuser   // status
);
    import ialu_pkg::*;

    localparam int W = DataWidth;

    state_t       state_reg, state_next;
    op_t          op_reg, op_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] i_reg, i_next;
    logic [W-1:0] mul_a_reg, mul_a_next;
    logic [W-1:0] mul_b_reg, mul_b_next;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0] res_reg, res_next;
    status_t      st_reg, st_next;
    logic         na_reg, na_next;
    logic         nb_reg, nb_next;
    div_req_t     dreq;
    div_rsp_t     drsp;

    logic [W-1:0] in_a, in_b;
    logic [W-1:0] mag_a, mag_b;
    logic         smax_ok;

    assign in_a  = s_tdata[0 +: W];
    assign in_b  = s_tdata[W +: W];
    assign mag_a = in_a[W-1] ? (~in_a + 1'b1) : in_a;
    assign mag_b = in_b[W-1] ? (~in_b + 1'b1) : in_b;
    assign smax_ok = (prod_reg[2*W-1:W-1] == '0);

    ialu_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        i_next     = i_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        dreq       = '{start: 1'b0, dividend: x_reg, divisor: y_reg};
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = op_t'(s_tuser);
                    a_next   = in_a;
                    b_next   = in_b;
                    na_next  = in_a[W-1];
                    nb_next  = in_b[W-1];
                    st_next  = ST_OK;
                    res_next = '0;
                    state_next = S_OUT;
                    case (op_t'(s_tuser))
                        OP_ADD: res_next = in_a + in_b;
                        OP_SUB: res_next = in_a - in_b;
                        OP_MUL: begin
                            mul_a_next = in_a;
                            mul_b_next = in_b;
                            state_next = S_MUL_WAIT;
                        end
                        OP_DIV, OP_MOD: begin
                            if (in_b == '0) begin
                                st_next = ST_DIVZERO;
                            end else begin
                                dreq.start    = 1'b1;
                                dreq.dividend = mag_a;
                                dreq.divisor  = mag_b;
                                state_next    = S_DIV;
                            end
                        end
                        OP_FACT: begin
                            res_next = W'(1);
                            if (!in_a[W-1] && in_a != '0) begin
                                i_next     = W'(1);
                                mul_a_next = W'(1);
                                mul_b_next = W'(1);
                                state_next = S_MUL_WAIT;
                            end
                        end
                        default: begin
                            if (in_a[W-1] || in_a == '0 || in_b[W-1] || in_b == '0) begin
                                st_next = ST_NONPOS;
                            end else begin
                                x_next        = in_a;
                                y_next        = in_b;
                                dreq.start    = 1'b1;
                                dreq.dividend = in_a;
                                dreq.divisor  = in_b;
                                state_next    = S_GCD_DIV;
                            end
                        end
                    endcase
                end
            end
            S_MUL_WAIT: begin
                // operands are registered, product lands in prod_reg next edge
                if (op_reg == OP_FACT) begin
                    state_next = S_FACT;
                end else if (op_reg == OP_LCM) begin
                    state_next = S_LCM_MUL;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                res_next   = prod_reg[W-1:0];
                state_next = S_OUT;
            end
            S_DIV: begin
                if (drsp.done) begin
                    if (op_reg == OP_DIV) begin
                        res_next = (na_reg != nb_reg) ? (~drsp.quot + 1'b1) : drsp.quot;
                    end else begin
                        res_next = na_reg ? (~drsp.rem + 1'b1) : drsp.rem;
                    end
                    state_next = S_OUT;
                end
            end
            S_FACT: begin
                // prod_reg holds i_reg!
                if (i_reg == a_reg || prod_reg[W-1:0] == '0) begin
                    res_next   = prod_reg[W-1:0];
                    state_next = S_OUT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    mul_a_next = prod_reg[W-1:0];
                    mul_b_next = i_reg + 1'b1;
                    state_next = S_MUL_WAIT;
                end
            end
            S_GCD_DIV: begin
                if (drsp.done) begin
                    x_next = y_reg;
                    y_next = drsp.rem;
                    state_next = S_GCD_STEP;
                end
            end
            S_GCD_STEP: begin
                if (y_reg == '0) begin
                    if (op_reg == OP_GCD) begin
                        res_next   = x_reg;
                        state_next = S_OUT;
                    end else begin
                        dreq.start    = 1'b1;
                        dreq.dividend = a_reg;
                        dreq.divisor  = x_reg;
                        state_next    = S_LCM_DIV;
                    end
                end else begin
                    dreq.start = 1'b1;
                    state_next = S_GCD_DIV;
                end
            end
            S_LCM_DIV: begin
                if (drsp.done) begin
                    mul_a_next = drsp.quot;
                    mul_b_next = b_reg;
                    state_next = S_MUL_WAIT;
                end
            end
            S_LCM_MUL: begin
                if (smax_ok) begin
                    res_next = prod_reg[W-1:0];
                end else begin
                    st_next = ST_OVERFLOW;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        i_reg     <= i_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= mul_a_reg * mul_b_reg;
        res_reg   <= res_next;
        st_reg    <= st_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = (st_reg == ST_OK) ? res_reg : '0;
    assign m_tuser  = st_reg;

    a_ready_valid_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero result with error status");

endmodule
